>>> hdl/bms_pkg.sv
`timescale 1ns / 1ps
package bms_pkg;

  localparam int MAX_CONES_DEF = 256;
  localparam int IDX_W = 13;   // wide enough to compare an 8-bit index against any table depth below 8192
  localparam int PW = 68;      // shared multiplier product width
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic signed [63:0] PI_Q = 64'sd205887;
  localparam logic signed [63:0] HALF_PI_Q = 64'sd102944;
  localparam logic signed [63:0] TWO_PI_Q = 64'sd411775;
  localparam logic signed [33:0] DEG2RAD_Q32 = 34'sd74961321;
  localparam logic signed [35:0] CORDIC_GAIN_Q30 = 36'sd652032874;
  localparam logic [32:0] HIT_DIST_Q16 = 33'd98304;
  localparam logic [34:0] HIT_DIST2_Q32 = 35'd9663676416;
  localparam int CORDIC_STEPS = 16;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [CFG_AW-1:0] {
    REG_WHEELBASE,
    REG_MAX_THROTTLE,
    REG_TOP_SPEED,
    REG_TIME_STEP,
    REG_CONE_COUNT
  } cfg_reg_t;

  typedef struct packed {
    logic              start;
    logic              vec_mode;
    logic signed [20:0] ang;
    logic signed [35:0] x0;
    logic signed [35:0] y0;
  } cordic_req_t;

  typedef struct packed {
    logic              done;
    logic signed [35:0] x;
    logic signed [35:0] y;
    logic signed [20:0] z;
  } cordic_rsp_t;

  typedef struct packed {
    logic              start;
    logic signed [63:0] dividend;
    logic [30:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic signed [63:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic              start;
    logic signed [31:0] px;
    logic signed [31:0] py;
  } cone_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } cone_rsp_t;

  function automatic logic signed [20:0] atan_q(input logic [3:0] i);
    logic signed [20:0] r;
    case (i)
      4'd0:  r = 21'sd51472;
      4'd1:  r = 21'sd30386;
      4'd2:  r = 21'sd16055;
      4'd3:  r = 21'sd8150;
      4'd4:  r = 21'sd4091;
      4'd5:  r = 21'sd2047;
      4'd6:  r = 21'sd1024;
      4'd7:  r = 21'sd512;
      4'd8:  r = 21'sd256;
      4'd9:  r = 21'sd128;
      4'd10: r = 21'sd64;
      4'd11: r = 21'sd32;
      4'd12: r = 21'sd16;
      4'd13: r = 21'sd8;
      4'd14: r = 21'sd4;
      default: r = 21'sd2;
    endcase
    return r;
  endfunction

  // shift right by k, rounding half away from zero
  function automatic logic signed [PW-1:0] rnd_shift(input logic signed [PW-1:0] v,
                                                      input int k);
    logic signed [PW-1:0] half;
    logic signed [PW-1:0] mag;
    logic signed [PW-1:0] r;
    half = PW'(1) <<< (k - 1);
    mag = v[PW-1] ? -v : v;
    r = (mag + half) >>> k;
    return v[PW-1] ? -r : r;
  endfunction

  function automatic logic signed [PW-1:0] sat32(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] r;
    if (v > PW'(64'sh7FFF_FFFF)) r = PW'(64'sh7FFF_FFFF);
    else if (v < -PW'(64'sh8000_0000)) r = -PW'(64'sh8000_0000);
    else r = v;
    return r;
  endfunction

endpackage

>>> hdl/bms_in_if.sv
`timescale 1ns / 1ps
interface bms_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [7:0]         cone_index;
  logic signed [31:0] cone_x;
  logic signed [31:0] cone_y;
  logic signed [23:0] steering_deg;
  logic signed [31:0] throttle_value;

  modport source(output valid, kind, cone_index, cone_x, cone_y, steering_deg,
                 throttle_value, input ready);
  modport sink(input valid, kind, cone_index, cone_x, cone_y, steering_deg,
               throttle_value, output ready);
endinterface

>>> hdl/bms_out_if.sv
`timescale 1ns / 1ps
interface bms_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [18:0] heading;
  logic signed [31:0] speed;
  logic               collided;

  modport source(output valid, pos_x, pos_y, heading, speed, collided, input ready);
  modport sink(input valid, pos_x, pos_y, heading, speed, collided, output ready);
endinterface

>>> hdl/bms_cfg_if.sv
`timescale 1ns / 1ps
interface bms_cfg_if;
  import bms_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_AW-1:0] addr;
  logic [CFG_DW-1:0] data;

  modport source(output valid, addr, data, input ready);
  modport sink(input valid, addr, data, output ready);
endinterface

>>> hdl/bms_ram.sv
`timescale 1ns / 1ps
module bms_ram #(
  parameter int W = 32,
  parameter int D = 256,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

>>> hdl/bms_div.sv
`timescale 1ns / 1ps
module bms_div (
  input  logic               clk,
  input  logic               rst_n,
  input  bms_pkg::div_req_t  req,
  output bms_pkg::div_rsp_t  rsp
);
  import bms_pkg::*;

  logic [63:0] q_r;
  logic [31:0] rem_r;
  logic [30:0] dvs_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        neg_r;
  logic        done_r;
  logic [32:0] trial;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_r, q_r[63]} - {2'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        neg_r <= req.dividend[63];
        q_r <= req.dividend[63] ? 64'(-req.dividend) : 64'(req.dividend);
        rem_r <= '0;
        dvs_r <= req.divisor;
        cnt_r <= 7'd64;
      end else if (busy_r) begin
        if (!trial[32]) rem_r <= trial[31:0];
        else rem_r <= {rem_r[30:0], q_r[63]};
        q_r <= {q_r[62:0], !trial[32]};
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = neg_r ? -$signed(q_r) : $signed(q_r);
endmodule

>>> hdl/bms_cordic.sv
`timescale 1ns / 1ps
module bms_cordic (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bms_pkg::cordic_req_t req,
  output bms_pkg::cordic_rsp_t rsp
);
  import bms_pkg::*;

  typedef enum logic [1:0] {C_IDLE, C_PREP, C_RUN, C_FIN} cstate_t;

  cstate_t            state_r;
  logic signed [35:0] x_r;
  logic signed [35:0] y_r;
  logic signed [20:0] z_r;
  logic [3:0]         i_r;
  logic               flip_r;
  logic               vec_r;
  logic               done_r;
  logic signed [35:0] xs;
  logic signed [35:0] ys;
  logic signed [20:0] at;

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign at = atan_q(i_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        C_IDLE: begin
          if (req.start) begin
            vec_r <= req.vec_mode;
            flip_r <= 1'b0;
            i_r <= '0;
            if (req.vec_mode) begin
              x_r <= req.x0;
              y_r <= req.y0;
              z_r <= '0;
              state_r <= C_RUN;
            end else begin
              x_r <= CORDIC_GAIN_Q30;
              y_r <= '0;
              z_r <= req.ang;
              state_r <= C_PREP;
            end
          end
        end
        C_PREP: begin
          // fold the angle into +-pi/2, one half turn a cycle
          if (z_r > 21'(HALF_PI_Q)) begin
            z_r <= z_r - 21'(PI_Q);
            flip_r <= !flip_r;
          end else if (z_r < -21'(HALF_PI_Q)) begin
            z_r <= z_r + 21'(PI_Q);
            flip_r <= !flip_r;
          end else begin
            state_r <= C_RUN;
          end
        end
        C_RUN: begin
          if (vec_r) begin
            if (!y_r[35]) begin
              x_r <= x_r + ys;
              y_r <= y_r - xs;
              z_r <= z_r + at;
            end else begin
              x_r <= x_r - ys;
              y_r <= y_r + xs;
              z_r <= z_r - at;
            end
          end else begin
            if (!z_r[20]) begin
              x_r <= x_r - ys;
              y_r <= y_r + xs;
              z_r <= z_r - at;
            end else begin
              x_r <= x_r + ys;
              y_r <= y_r - xs;
              z_r <= z_r + at;
            end
          end
          i_r <= i_r + 4'd1;
          if (i_r == 4'(CORDIC_STEPS - 1)) state_r <= C_FIN;
        end
        C_FIN: begin
          if (flip_r && !vec_r) begin
            x_r <= -x_r;
            y_r <= -y_r;
          end
          done_r <= 1'b1;
          state_r <= C_IDLE;
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.x = x_r;
  assign rsp.y = y_r;
  assign rsp.z = z_r;
endmodule

>>> hdl/bms_cone.sv
`timescale 1ns / 1ps
module bms_cone #(
  parameter int AW = 8,
  parameter int CW = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bms_pkg::cone_req_t req,
  input  logic [CW-1:0]      n,
  output logic [AW-1:0]      raddr,
  input  logic signed [31:0] rd_x,
  input  logic signed [31:0] rd_y,
  output bms_pkg::cone_rsp_t rsp
);
  import bms_pkg::*;

  logic [CW-1:0]      cnt_r;
  logic               busy_r;
  logic               v1_r;
  logic               v2_r;
  logic               v3_r;
  logic               hit_r;
  logic               near_r;
  logic signed [31:0] px_r;
  logic signed [31:0] py_r;
  logic [32:0]        ax_r;
  logic [32:0]        ay_r;
  logic [33:0]        sqx_r;
  logic [33:0]        sqy_r;
  logic signed [32:0] ex;
  logic signed [32:0] ey;
  logic               issue;

  assign issue = busy_r && (cnt_r != n);
  assign raddr = cnt_r[AW-1:0];
  assign ex = 33'(px_r) - 33'(rd_x);
  assign ey = 33'(py_r) - 33'(rd_y);

  // read, abs difference, squares, compare: one cone per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
        hit_r <= 1'b0;
        px_r <= req.px;
        py_r <= req.py;
      end else begin
        if (issue) cnt_r <= cnt_r + CW'(1);
        if (rsp.done) busy_r <= 1'b0;
      end
      if (v1_r) begin
        ax_r <= ex[32] ? 33'(-ex) : 33'(ex);
        ay_r <= ey[32] ? 33'(-ey) : 33'(ey);
      end
      if (v2_r) begin
        near_r <= (ax_r < HIT_DIST_Q16) && (ay_r < HIT_DIST_Q16);
        sqx_r <= 34'(ax_r[16:0]) * 34'(ax_r[16:0]);
        sqy_r <= 34'(ay_r[16:0]) * 34'(ay_r[16:0]);
      end
      if (v3_r && near_r && ((35'(sqx_r) + 35'(sqy_r)) < HIT_DIST2_Q32)) hit_r <= 1'b1;
    end
  end

  assign rsp.done = busy_r && (cnt_r == n) && !v1_r && !v2_r && !v3_r;
  assign rsp.hit = hit_r;
endmodule

>>> hdl/bicycle_model_step_with_collision.sv
`timescale 1ns / 1ps
// Load request: the x and y cone RAMs are written on accept; the result then goes through S_DONE.
// Tick request: work is set by two 64-step divisions, three CORDIC runs and a one-cone-per-cycle
//   scan over min(cone_count, MAX_CONES) cones.
// One request in work at a time; the next is taken while a result waits in the output register.
// Reset (rst_n low, synchronous): registers to defaults, car at (40 m, 30 m), heading and
//   speed zero; the cone table is not cleared.
module bicycle_model_step_with_collision #(
  parameter int MAX_CONES = bms_pkg::MAX_CONES_DEF
) (
  input logic       clk,
  input logic       rst_n,
  bms_in_if.sink    in_ch,
  bms_out_if.source out_ch,
  bms_cfg_if.sink   cfg_ch
);
  import bms_pkg::*;

  localparam int AW = (MAX_CONES > 1) ? $clog2(MAX_CONES) : 1;
  localparam int CW = $clog2(MAX_CONES + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_DMUL, S_DRND, S_VDIV, S_VWAIT,
    S_SC1, S_SC1W, S_VEC, S_VECW, S_SC2, S_SC2W,
    S_X1, S_X2, S_X3, S_X4, S_Y1, S_Y2, S_Y3, S_Y4,
    S_CONE, S_CONEW, S_H1, S_H2, S_H3, S_H4, S_HDIV, S_HWAIT, S_HWRAP, S_DONE
  } state_t;

  state_t state_r;

  // configuration
  logic [30:0] wheelbase_r;
  logic [30:0] max_throttle_r;
  logic [30:0] top_speed_r;
  logic [16:0] time_step_r;
  logic [8:0]  cone_count_r;

  // vehicle state
  logic signed [31:0] car_x_r;
  logic signed [31:0] car_y_r;
  logic signed [18:0] heading_r;
  logic signed [31:0] speed_r;

  // tick working registers
  logic signed [23:0]   steer_r;
  logic signed [31:0]   thr_r;
  logic signed [PW-1:0] prod_r;
  logic signed [35:0]   tmp_r;
  logic signed [20:0]   delta_r;
  logic signed [20:0]   beta_r;
  logic signed [31:0]   v_r;
  logic signed [33:0]   sd_r;
  logic signed [33:0]   cd_r;
  logic signed [33:0]   sp_r;
  logic signed [33:0]   cp_r;
  logic signed [31:0]   px_r;
  logic signed [31:0]   py_r;
  logic signed [63:0]   hsum_r;
  logic                 hit_r;

  // output register
  logic               out_valid_r;
  logic signed [31:0] out_x_r;
  logic signed [31:0] out_y_r;
  logic signed [18:0] out_h_r;
  logic signed [31:0] out_v_r;
  logic               out_c_r;

  logic in_acc;
  logic cfg_acc;
  logic signed [33:0]   mul_a;
  logic signed [33:0]   mul_b;
  logic signed [PW-1:0] mul_p;
  logic signed [63:0]   h_wrap;
  logic signed [63:0]   h_clamp;
  logic [IDX_W-1:0]     idx_ext;
  logic [IDX_W-1:0]     cc_ext;
  logic [IDX_W-1:0]     n_lim;
  logic                 ram_we;
  logic [AW-1:0]        ram_raddr;
  logic [31:0]          ram_x;
  logic [31:0]          ram_y;
  logic [30:0]          mt_eff;
  logic [30:0]          wb_eff;

  cordic_req_t cor_req;
  cordic_rsp_t cor_rsp;
  div_req_t    div_req;
  div_rsp_t    div_rsp;
  cone_req_t   cone_req;
  cone_rsp_t   cone_rsp;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  // zero divisors behave as one
  assign mt_eff = (max_throttle_r == '0) ? 31'd1 : max_throttle_r;
  assign wb_eff = (wheelbase_r == '0) ? 31'd1 : wheelbase_r;

  // loads beyond the table are dropped
  assign idx_ext = IDX_W'(in_ch.cone_index);
  assign ram_we = in_acc && (in_ch.kind == KIND_LOAD) && (idx_ext < IDX_W'(MAX_CONES));

  assign cc_ext = IDX_W'(cone_count_r);
  assign n_lim = (cc_ext > IDX_W'(MAX_CONES)) ? IDX_W'(MAX_CONES) : cc_ext;

  bms_ram #(.W(32), .D(MAX_CONES)) u_ram_x (
    .clk(clk), .we(ram_we), .waddr(idx_ext[AW-1:0]), .wdata(in_ch.cone_x),
    .raddr(ram_raddr), .rdata(ram_x)
  );

  bms_ram #(.W(32), .D(MAX_CONES)) u_ram_y (
    .clk(clk), .we(ram_we), .waddr(idx_ext[AW-1:0]), .wdata(in_ch.cone_y),
    .raddr(ram_raddr), .rdata(ram_y)
  );

  bms_cordic u_cordic (.clk(clk), .rst_n(rst_n), .req(cor_req), .rsp(cor_rsp));
  bms_div    u_div    (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  bms_cone #(.AW(AW), .CW(CW)) u_cone (
    .clk(clk), .rst_n(rst_n), .req(cone_req), .n(CW'(n_lim)), .raddr(ram_raddr),
    .rd_x($signed(ram_x)), .rd_y($signed(ram_y)), .rsp(cone_rsp)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_DMUL: begin
        mul_a = 34'(steer_r);
        mul_b = DEG2RAD_Q32;
      end
      S_DRND: begin
        mul_a = 34'(thr_r);
        mul_b = $signed({3'b0, top_speed_r});
      end
      S_X1: begin
        mul_a = 34'(v_r);
        mul_b = cp_r;
      end
      S_Y1: begin
        mul_a = 34'(v_r);
        mul_b = sp_r;
      end
      S_H1: begin
        mul_a = 34'(v_r);
        mul_b = sd_r;
      end
      S_X3, S_Y3, S_H3: begin
        mul_a = tmp_r[33:0];
        mul_b = $signed({17'b0, time_step_r});
      end
      default: ;
    endcase
  end

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  always_comb begin
    cor_req = '0;
    case (state_r)
      S_SC1: begin
        cor_req.start = 1'b1;
        cor_req.ang = delta_r;
      end
      S_VEC: begin
        // slip angle: vector (sin, 2 cos), mirrored into the right half plane
        cor_req.start = 1'b1;
        cor_req.vec_mode = 1'b1;
        if (cd_r[33]) begin
          cor_req.y0 = -36'(sd_r);
          cor_req.x0 = -(36'(cd_r) <<< 1);
        end else begin
          cor_req.y0 = 36'(sd_r);
          cor_req.x0 = 36'(cd_r) <<< 1;
        end
      end
      S_SC2: begin
        cor_req.start = 1'b1;
        cor_req.ang = 21'(heading_r) + beta_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    div_req = '0;
    case (state_r)
      S_VDIV: begin
        div_req.start = 1'b1;
        div_req.dividend = 64'(prod_r);
        div_req.divisor = mt_eff;
      end
      S_HDIV: begin
        div_req.start = 1'b1;
        div_req.dividend = 64'(tmp_r) <<< 16;
        div_req.divisor = wb_eff;
      end
      default: ;
    endcase
  end

  assign cone_req.start = (state_r == S_CONE);
  assign cone_req.px = px_r;
  assign cone_req.py = py_r;

  // single wrap into +-pi, then clamp
  always_comb begin
    if (hsum_r > PI_Q) h_wrap = hsum_r - TWO_PI_Q;
    else if (hsum_r < -PI_Q) h_wrap = hsum_r + TWO_PI_Q;
    else h_wrap = hsum_r;
    if (h_wrap > PI_Q) h_clamp = PI_Q;
    else if (h_wrap < -PI_Q) h_clamp = -PI_Q;
    else h_clamp = h_wrap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      wheelbase_r <= 31'd98304;
      max_throttle_r <= 31'd65536;
      top_speed_r <= 31'd655360;
      time_step_r <= 17'd1092;
      cone_count_r <= 9'd0;
      car_x_r <= 32'sd2621440;
      car_y_r <= 32'sd1966080;
      heading_r <= '0;
      speed_r <= '0;
      hit_r <= 1'b0;
    end else begin
      if (cfg_acc) begin
        case (cfg_ch.addr)
          REG_WHEELBASE:    wheelbase_r <= cfg_ch.data[30:0];
          REG_MAX_THROTTLE: max_throttle_r <= cfg_ch.data[30:0];
          REG_TOP_SPEED:    top_speed_r <= cfg_ch.data[30:0];
          REG_TIME_STEP:    time_step_r <= cfg_ch.data[16:0];
          REG_CONE_COUNT:   cone_count_r <= cfg_ch.data[8:0];
          default: ;
        endcase
      end

      // output valid: set when a result is loaded, cleared when taken
      if (state_r == S_DONE && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            steer_r <= in_ch.steering_deg;
            thr_r <= in_ch.throttle_value;
            hit_r <= 1'b0;
            state_r <= (in_ch.kind == KIND_TICK) ? S_DMUL : S_DONE;
          end
        end
        S_DMUL: begin
          prod_r <= mul_p;
          state_r <= S_DRND;
        end
        S_DRND: begin
          // degrees to radians, then throttle * top speed
          delta_r <= 21'(rnd_shift(prod_r, 32));
          prod_r <= mul_p;
          state_r <= S_VDIV;
        end
        S_VDIV: state_r <= S_VWAIT;
        S_VWAIT: begin
          if (div_rsp.done) begin
            v_r <= 32'(sat32(PW'(div_rsp.quot)));
            state_r <= S_SC1;
          end
        end
        S_SC1: state_r <= S_SC1W;
        S_SC1W: begin
          if (cor_rsp.done) begin
            sd_r <= 34'(cor_rsp.y);
            cd_r <= 34'(cor_rsp.x);
            state_r <= S_VEC;
          end
        end
        S_VEC: state_r <= S_VECW;
        S_VECW: begin
          if (cor_rsp.done) begin
            beta_r <= cor_rsp.z;
            state_r <= S_SC2;
          end
        end
        S_SC2: state_r <= S_SC2W;
        S_SC2W: begin
          if (cor_rsp.done) begin
            sp_r <= 34'(cor_rsp.y);
            cp_r <= 34'(cor_rsp.x);
            state_r <= S_X1;
          end
        end
        // proposed x
        S_X1: begin
          prod_r <= mul_p;
          state_r <= S_X2;
        end
        S_X2: begin
          tmp_r <= 36'(rnd_shift(prod_r, 30));
          state_r <= S_X3;
        end
        S_X3: begin
          prod_r <= mul_p;
          state_r <= S_X4;
        end
        S_X4: begin
          px_r <= 32'(sat32(PW'(car_x_r) + rnd_shift(prod_r, 16)));
          state_r <= S_Y1;
        end
        // proposed y
        S_Y1: begin
          prod_r <= mul_p;
          state_r <= S_Y2;
        end
        S_Y2: begin
          tmp_r <= 36'(rnd_shift(prod_r, 30));
          state_r <= S_Y3;
        end
        S_Y3: begin
          prod_r <= mul_p;
          state_r <= S_Y4;
        end
        S_Y4: begin
          py_r <= 32'(sat32(PW'(car_y_r) + rnd_shift(prod_r, 16)));
          state_r <= S_CONE;
        end
        S_CONE: state_r <= S_CONEW;
        S_CONEW: begin
          if (cone_rsp.done) begin
            hit_r <= cone_rsp.hit;
            if (cone_rsp.hit) v_r <= '0;
            state_r <= S_H1;
          end
        end
        // heading step: v * sin(delta) * dt / wheelbase
        S_H1: begin
          prod_r <= mul_p;
          state_r <= S_H2;
        end
        S_H2: begin
          tmp_r <= 36'(rnd_shift(prod_r, 30));
          state_r <= S_H3;
        end
        S_H3: begin
          prod_r <= mul_p;
          state_r <= S_H4;
        end
        S_H4: begin
          tmp_r <= 36'(rnd_shift(prod_r, 16));
          state_r <= S_HDIV;
        end
        S_HDIV: state_r <= S_HWAIT;
        S_HWAIT: begin
          if (div_rsp.done) begin
            hsum_r <= 64'(heading_r) + div_rsp.quot;
            state_r <= S_HWRAP;
          end
        end
        S_HWRAP: begin
          heading_r <= 19'(h_clamp);
          speed_r <= v_r;
          if (!hit_r) begin
            car_x_r <= px_r;
            car_y_r <= py_r;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_x_r <= car_x_r;
            out_y_r <= car_y_r;
            out_h_r <= heading_r;
            out_v_r <= speed_r;
            out_c_r <= hit_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.pos_x = out_x_r;
  assign out_ch.pos_y = out_y_r;
  assign out_ch.heading = out_h_r;
  assign out_ch.speed = out_v_r;
  assign out_ch.collided = out_c_r;

`ifndef SYNTH
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    (heading_r <= 19'sd205887) && (heading_r >= -19'sd205887))
    else $error("heading outside +-pi");

  a_hit_holds_pose: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HWRAP && hit_r) |=> (car_x_r == $past(car_x_r)) &&
    (car_y_r == $past(car_y_r)) && (speed_r == '0))
    else $error("collision moved the car");

  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_VWAIT || state_r == S_HWAIT))
    else $error("divider result not awaited");

  a_cordic_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    cor_rsp.done |-> (state_r == S_SC1W || state_r == S_VECW || state_r == S_SC2W))
    else $error("cordic result not awaited");

  a_load_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.kind == KIND_LOAD) |=> (state_r == S_DONE) && !hit_r)
    else $error("load request flagged a collision");
`endif
endmodule
